// ===== rtl/pli_pkg.sv =====
// ----------------------------------------------------------------------------
// pli_pkg: shared types and constants of the positional list
// Sizes, operation and status codes, and the control word broadcast to cells.
// ----------------------------------------------------------------------------
package pli_pkg;

	// list capacity and derived widths
	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 8;
	localparam int DATA_W = 32;
	// compare width: room for position, count and count+1
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// read-out OR tree grouping
	localparam int GRP = 8;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;

	// operation codes
	typedef enum logic [1:0] {
		FN_INS  = 2'd0,
		FN_DEL  = 2'd1,
		FN_RD   = 2'd2,
		FN_NOP  = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// control word broadcast along the row of cells
	typedef struct packed {
		logic             ins;
		logic             del;
		logic             rd;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// ===== rtl/positional_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete: ordered list with positional insert/delete
// A row of cells holds the list head first; reads go through an OR tree.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | words
//  ---------+-----------+--------------------+-------------------------------
//  command  | in        | start high, !busy  | func, position, value
//  result   | out       | strobe, one cycle  | status, element_count, read_value
//
//  The cells shift and the read OR tree's first level is registered on
//  acceptance; while busy is high, in the cycle after, the result registers
//  take the second level, so no new word enters while the last is in the
//  read tree. Reset empties the list; the cell contents are not cleared.
//  The receiver cannot stall: strobe marks a result for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  func,
	input  logic [pli_pkg::POS_W-1:0]   position,
	input  logic signed [pli_pkg::DATA_W-1:0] value,
	output logic                        strobe,
	output logic [1:0]                  status,
	output logic [pli_pkg::CNT_W-1:0]   element_count,
	output logic signed [pli_pkg::DATA_W-1:0] read_value
);

	logic                         accept;
	logic [pli_pkg::CNT_W-1:0]    cnt_q;
	logic [pli_pkg::CNT_W-1:0]    cnt_d;
	logic                         busy_q;
	logic                         strobe_q;
	pli_pkg::status_t             st_d;
	pli_pkg::status_t             st_s1;
	pli_pkg::status_t             status_q;
	logic [pli_pkg::CNT_W-1:0]    count_q;
	logic [pli_pkg::DATA_W-1:0]   rdval_q;
	logic [pli_pkg::CMP_W-1:0]    pos_w;
	logic [pli_pkg::CMP_W-1:0]    cnt_w;
	logic [pli_pkg::CMP_W-1:0]    idx_w;
	logic                         full;
	logic                         empty;
	pli_pkg::cell_ctl_t           ctl;
	logic [pli_pkg::DATA_W-1:0]   cell_word [pli_pkg::DEPTH];
	logic [pli_pkg::DATA_W-1:0]   cell_rd   [pli_pkg::DEPTH];
	logic [pli_pkg::DATA_W-1:0]   grp_d     [pli_pkg::NGRP];
	logic [pli_pkg::DATA_W-1:0]   grp_s1    [pli_pkg::NGRP];
	logic [pli_pkg::DATA_W-1:0]   rd_or;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	assign pos_w = pli_pkg::CMP_W'(position);
	assign cnt_w = pli_pkg::CMP_W'(cnt_q);
	assign full  = (cnt_q == pli_pkg::CNT_W'(pli_pkg::DEPTH));
	assign empty = (cnt_q == '0);

	// decode: clamp an insert or delete position, range-check a read, pick status and next count
	always_comb begin
		idx_w = '0;
		st_d  = pli_pkg::ST_OK;
		cnt_d = cnt_q;
		ctl   = '0;
		unique case (pli_pkg::func_t'(func))
			pli_pkg::FN_INS: begin
				if (full) begin
					st_d = pli_pkg::ST_FULL;
				end else begin
					priority if (pos_w <= pli_pkg::CMP_W'(1)) begin
						idx_w = '0;
					end else if (pos_w >= cnt_w + pli_pkg::CMP_W'(1)) begin
						idx_w = cnt_w;
					end else begin
						idx_w = pos_w - pli_pkg::CMP_W'(1);
					end
					ctl.ins = accept;
					cnt_d   = cnt_q + pli_pkg::CNT_W'(1);
				end
			end
			pli_pkg::FN_DEL: begin
				if (empty) begin
					st_d = pli_pkg::ST_EMPTY;
				end else begin
					priority if (pos_w <= pli_pkg::CMP_W'(1)) begin
						idx_w = '0;
					end else if (pos_w > cnt_w) begin
						idx_w = cnt_w - pli_pkg::CMP_W'(1);
					end else begin
						idx_w = pos_w - pli_pkg::CMP_W'(1);
					end
					ctl.del = accept;
					cnt_d   = cnt_q - pli_pkg::CNT_W'(1);
				end
			end
			pli_pkg::FN_RD: begin
				if ((pos_w == '0) || (pos_w > cnt_w)) begin
					st_d = pli_pkg::ST_RANGE;
				end else begin
					idx_w  = pos_w - pli_pkg::CMP_W'(1);
					ctl.rd = accept;
				end
			end
			pli_pkg::FN_NOP: begin
				st_d = pli_pkg::ST_OK;
			end
			default: begin
				st_d = pli_pkg::ST_OK;
			end
		endcase
		ctl.idx = idx_w[pli_pkg::IDX_W-1:0];
	end

	// row of cells, each fed by its neighbours
	for (genvar i = 0; i < pli_pkg::DEPTH; i++) begin : g_cell
		logic [pli_pkg::DATA_W-1:0] left_w;
		logic [pli_pkg::DATA_W-1:0] right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == pli_pkg::DEPTH - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end
		pli_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.my_index   (pli_pkg::IDX_W'(i)),
			.ins_word   (value),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rd_word    (cell_rd[i])
		);
	end

	// read tree, first level: OR within each group of cells
	always_comb begin
		for (int g = 0; g < pli_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < pli_pkg::GRP; k++) begin
				if (g * pli_pkg::GRP + k < pli_pkg::DEPTH) begin
					grp_d[g] = grp_d[g] | cell_rd[g * pli_pkg::GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1 <= grp_d;
			st_s1  <= st_d;
		end
	end

	// read tree, second level: OR across the groups
	always_comb begin
		rd_or = '0;
		for (int g = 0; g < pli_pkg::NGRP; g++) begin
			rd_or = rd_or | grp_s1[g];
		end
	end

	// control: count, busy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q <= cnt_d;
			end
			busy_q   <= accept;
			strobe_q <= busy_q;
		end
	end

	// result word registers
	always_ff @(posedge clk) begin
		if (busy_q) begin
			status_q <= st_s1;
			count_q  <= cnt_q;
			rdval_q  <= rd_or;
		end
	end

	assign strobe        = strobe_q;
	assign status        = status_q;
	assign element_count = count_q;
	assign read_value    = rdval_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after acceptance");

	a_strobe_follows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> strobe_q)
		else $error("result strobe missing");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pli_pkg::CNT_W'(pli_pkg::DEPTH))
		else $error("element count above capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (status_q == pli_pkg::ST_FULL)) |->
		(count_q == pli_pkg::CNT_W'(pli_pkg::DEPTH)))
		else $error("full status with room left");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (status_q == pli_pkg::ST_EMPTY)) |-> (count_q == '0))
		else $error("empty status with elements held");

endmodule

// ===== rtl/pli_cell.sv =====
// ----------------------------------------------------------------------------
// pli_cell: one storage cell of the positional list
// Holds one word; on insert takes its left neighbour or the new word, on delete its right.
// ----------------------------------------------------------------------------
module pli_cell (
	input  logic                      clk,
	input  pli_pkg::cell_ctl_t        ctl,
	input  logic [pli_pkg::IDX_W-1:0] my_index,
	input  logic [pli_pkg::DATA_W-1:0] ins_word,
	input  logic [pli_pkg::DATA_W-1:0] left_word,
	input  logic [pli_pkg::DATA_W-1:0] right_word,
	output logic [pli_pkg::DATA_W-1:0] word,
	output logic [pli_pkg::DATA_W-1:0] rd_word
);

	logic [pli_pkg::DATA_W-1:0] word_q;
	logic [pli_pkg::DATA_W-1:0] word_d;

	// next word: shift right past the insert point, left from the delete point
	always_comb begin
		word_d = word_q;
		priority if (ctl.ins && (my_index > ctl.idx)) begin
			word_d = left_word;
		end else if (ctl.ins && (my_index == ctl.idx)) begin
			word_d = ins_word;
		end else if (ctl.del && (my_index >= ctl.idx)) begin
			word_d = right_word;
		end else begin
			word_d = word_q;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;
	// masked read-out, zero unless this cell is addressed
	assign rd_word = (ctl.rd && (my_index == ctl.idx)) ? word_q : '0;

endmodule
